// ===== design/fsl_pkg.sv =====
// Shared types and constants of the free-list slot allocator.
package fsl_pkg;

  localparam int DEFAULT_POOL_DEPTH = 4096;

  localparam int SLOT_W  = 16;
  localparam int GRANT_W = 12;
  localparam int COUNT_W = 13;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot_index;
    logic              is_null;
  } in_item_t;

  typedef struct packed {
    logic               success;
    logic [GRANT_W-1:0] granted_index;
    logic [COUNT_W-1:0] free_count;
  } out_item_t;

  // Decision of the stack for the transaction accepted in this cycle.
  typedef struct packed {
    logic               success;
    logic               grant;
    logic [COUNT_W-1:0] count;
  } stk_resp_t;

  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_RUN  = 2'b10
  } stk_state_t;

endpackage

// ===== design/fsl_stack.sv =====
// Free-index stack: memory, stack pointer and the fill sweep after reset.
module fsl_stack #(
  parameter int POOL_DEPTH = fsl_pkg::DEFAULT_POOL_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  input  fsl_pkg::in_item_t               req,
  output logic                            ready,
  output fsl_pkg::stk_resp_t              resp,
  output logic [$clog2(POOL_DEPTH)-1:0]   rd_data
);

  localparam int ADDR_W = $clog2(POOL_DEPTH);
  localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_DEPTH - 1);
  localparam logic [PTR_W-1:0]  FULL_PTR  = PTR_W'(POOL_DEPTH);

  logic [ADDR_W-1:0] mem [POOL_DEPTH];

  fsl_pkg::stk_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [PTR_W-1:0]    top_r, top_nxt;
  logic [ADDR_W-1:0]   rd_data_r;

  logic              slot_ok;
  logic              pop_ok;
  logic              push_ok;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;

  assign ready   = (state_r == fsl_pkg::ST_RUN);
  assign slot_ok = 32'(req.slot_index) < 32'(POOL_DEPTH);
  assign pop_ok  = req_valid && ready && (req.action == fsl_pkg::ACT_ALLOC)
                   && (top_r != '0);
  assign push_ok = req_valid && ready && (req.action == fsl_pkg::ACT_FREE)
                   && !req.is_null && slot_ok && (top_r != FULL_PTR);

  // A pop reads the entry below the pointer; a push in the previous cycle
  // has already landed in memory, so no forwarding is needed.
  assign rd_addr = ADDR_W'(top_r - PTR_W'(1));

  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    top_nxt      = top_r;
    wr_en        = 1'b0;
    wr_addr      = ADDR_W'(top_r);
    wr_data      = ADDR_W'(req.slot_index);
    unique case (state_r)
      fsl_pkg::ST_FILL: begin
        wr_en        = 1'b1;
        wr_addr      = fill_cnt_r;
        wr_data      = LAST_ADDR - fill_cnt_r;
        fill_cnt_nxt = fill_cnt_r + ADDR_W'(1);
        if (fill_cnt_r == LAST_ADDR) begin
          state_nxt = fsl_pkg::ST_RUN;
        end
      end
      fsl_pkg::ST_RUN: begin
        if (pop_ok) begin
          top_nxt = top_r - PTR_W'(1);
        end else if (push_ok) begin
          wr_en   = 1'b1;
          top_nxt = top_r + PTR_W'(1);
        end
      end
      default: begin
        state_nxt = fsl_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fsl_pkg::ST_FILL;
      fill_cnt_r <= '0;
      top_r      <= FULL_PTR;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      top_r      <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data      = rd_data_r;
  assign resp.success = pop_ok || push_ok;
  assign resp.grant   = pop_ok;
  assign resp.count   = fsl_pkg::COUNT_W'(top_nxt);

endmodule

// ===== design/free_list_slot_allocator.sv =====
// Top level of the free-list slot allocator: stack plus result register.
//
//   channel | ports                    | handshake
//   --------+--------------------------+-------------------------------------
//   request | start, busy, in_data     | taken when start is high, busy low
//   result  | out_valid, out_data      | one-cycle strobe, cannot be stalled
//
// After reset the stack is filled one entry per cycle, so busy stays high
// after rst_n is released until all POOL_DEPTH entries are written.
// Afterwards one transaction is taken every cycle; its result appears on the
// cycle after acceptance, through the result and memory read registers.
// Busy is low whenever the fill is done; the result side never stalls.
module free_list_slot_allocator #(
  parameter int POOL_DEPTH = fsl_pkg::DEFAULT_POOL_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fsl_pkg::in_item_t   in_data,
  output logic                out_valid,
  output fsl_pkg::out_item_t  out_data
);

  localparam int ADDR_W = $clog2(POOL_DEPTH);

  logic               ready;
  logic               accept;
  fsl_pkg::stk_resp_t resp;
  logic [ADDR_W-1:0]  rd_data;

  logic                        out_valid_r;
  logic                        success_r;
  logic                        grant_r;
  logic [fsl_pkg::COUNT_W-1:0] count_r;

  assign busy   = !ready;
  assign accept = start && ready;

  fsl_stack #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (accept),
    .req       (in_data),
    .ready     (ready),
    .resp      (resp),
    .rd_data   (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    success_r <= resp.success;
    grant_r   <= resp.grant;
    count_r   <= resp.count;
  end

  // The granted index is zero unless an allocate succeeded.
  assign out_valid               = out_valid_r;
  assign out_data.success        = success_r;
  assign out_data.granted_index  = grant_r ? fsl_pkg::GRANT_W'(rd_data)
                                           : '0;
  assign out_data.free_count     = count_r;

endmodule
